>>> src/per_key_ema_flow_meter_unit_macros.svh
// Assertion macros for the flow meter block.
// Used by the port checker; no other dependencies.
`ifndef PER_KEY_EMA_FLOW_METER_UNIT_MACROS_SVH
`define PER_KEY_EMA_FLOW_METER_UNIT_MACROS_SVH

// same-cycle implication
`define PKEFM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define PKEFM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication that is also checked across reset
`define PKEFM_ASSERT_RST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/pkefm_pkg.sv
// Shared types and constants of the flow meter block.
// No dependencies.
`default_nettype none
package pkefm_pkg;

    typedef struct packed {
        logic [63:0] out_value_sum;
        logic [63:0] out_qty_sum;
        logic [63:0] in_value_sum;
        logic [63:0] ema_output;
        logic [63:0] ema_input;
        logic [63:0] ema_unit_price;
    } meter_t;

    localparam logic [1:0] MODE_RECORD = 2'd0;
    localparam logic [1:0] MODE_TICK   = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_IGNORED   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [10:0] WINDOW_RESET = 11'd64;

    localparam logic [2:0] STEP_OUT     = 3'd0;
    localparam logic [2:0] STEP_EMA_OUT = 3'd1;
    localparam logic [2:0] STEP_IN      = 3'd2;
    localparam logic [2:0] STEP_EMA_IN  = 3'd3;
    localparam logic [2:0] STEP_PRICE   = 3'd4;
    localparam logic [2:0] STEP_EMA_PR  = 3'd5;

endpackage
`default_nettype wire

>>> src/pkefm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pkefm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire                                    aclk,
    input  wire                                    we,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire [WIDTH-1:0]                        wdata,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> src/pkefm_div.sv
// Bit-serial divider: signed 64-bit dividend by positive 32-bit divisor,
// truncating toward zero, one quotient bit per cycle. No dependencies.
`default_nettype none
module pkefm_div (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         start,
    input  wire  [63:0] dividend,
    input  wire  [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    logic [63:0] q_reg;
    logic [31:0] rem_reg;
    logic [31:0] d_reg;
    logic [6:0]  cnt_reg;
    logic        neg_reg;
    logic        busy_reg;
    logic [32:0] rem_sh;
    logic        fit;

    assign rem_sh = {rem_reg, q_reg[63]};
    assign fit    = rem_sh >= {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= 7'd0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
                neg_reg  <= dividend[63];
                q_reg    <= dividend[63] ? (64'd0 - dividend) : dividend;
                rem_reg  <= 32'd0;
                d_reg    <= divisor;
            end else if (busy_reg) begin
                rem_reg <= fit ? 32'(rem_sh - {1'b0, d_reg}) : rem_sh[31:0];
                q_reg   <= {q_reg[62:0], fit};
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    assign quotient = neg_reg ? (64'd0 - q_reg) : q_reg;
endmodule
`default_nettype wire

>>> src/per_key_ema_flow_meter_unit.sv
// Flow meter top level: keyed meter table, sequencer and output register.
// Depends on pkefm_pkg, pkefm_ram and pkefm_div.
// Record/query: linear search of the filled entries, then a read of the matched entry.
// Tick: six serial divides per filled entry; the price divide is skipped with no price.
// One request at a time; result held in an output register until taken.
// Reset empties the table at once via the fill count; window resets to 64.
`default_nettype none
module per_key_ema_flow_meter_unit #(
    parameter int ENTRIES = 1024
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire  [10:0] cfg_wr_data,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [1:0]  s_mode,
    input  wire  [31:0] s_org_key,
    input  wire  [31:0] s_unit_value,
    input  wire  [63:0] s_quantity,
    input  wire  [30:0] s_tick_count,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [1:0]  m_status,
    output logic [63:0] m_output_rate,
    output logic [63:0] m_input_rate,
    output logic [63:0] m_net_rate,
    output logic [63:0] m_price_level
);
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int MW = $bits(pkefm_pkg::meter_t);
    localparam logic [CW-1:0] FULL = CW'(ENTRIES);

    typedef enum logic [3:0] {
        IDLE, SRD, SCMP, ALLOC, DRD, DWAIT, MUL, UPD,
        TRD, TWAIT, DGO, DWT, TWR, FIN
    } state_t;

    state_t state_reg;
    logic [10:0] window_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] idx_reg;
    logic [1:0]  mode_reg;
    logic [31:0] key_reg;
    logic [31:0] uv_reg;
    logic [63:0] qty_reg;
    logic [30:0] ticks_reg;
    logic [1:0]  status_reg;
    logic        hit_reg;
    logic [2:0]  step_reg;
    logic [63:0] sout_reg;
    logic [63:0] sin_reg;
    logic [63:0] sp_reg;
    logic signed [63:0] prod_reg;
    pkefm_pkg::meter_t cur_reg;

    logic [31:0] key_rdata;
    logic [MW-1:0] data_rdata;
    pkefm_pkg::meter_t rd_meter;
    logic key_we;
    logic data_we;
    pkefm_pkg::meter_t wr_meter;

    logic div_start;
    logic [63:0] div_a;
    logic [31:0] div_b;
    logic div_done;
    logic [63:0] div_q;
    logic [31:0] win_eff;
    logic price_ok;
    logic [63:0] prod_abs;
    logic [63:0] add_val;

    assign rd_meter = pkefm_pkg::meter_t'(data_rdata);
    assign win_eff  = (window_reg == 11'd0) ? 32'd1 : {21'd0, window_reg};
    assign price_ok = !cur_reg.out_qty_sum[63] && (cur_reg.out_qty_sum[62:32] != 31'd0);
    assign prod_abs = prod_reg[63] ? (64'd0 - prod_reg) : prod_reg;
    assign add_val  = {prod_abs[47:0], 16'd0};
    assign s_ready  = (state_reg == IDLE);

    pkefm_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_key_ram (
        .aclk(aclk), .we(key_we), .waddr(cnt_reg[AW-1:0]), .wdata(key_reg),
        .raddr(idx_reg[AW-1:0]), .rdata(key_rdata)
    );

    pkefm_ram #(.WIDTH(MW), .DEPTH(ENTRIES)) u_data_ram (
        .aclk(aclk), .we(data_we), .waddr(idx_reg[AW-1:0]), .wdata(wr_meter),
        .raddr(idx_reg[AW-1:0]), .rdata(data_rdata)
    );

    pkefm_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_a),
        .divisor(div_b), .done(div_done), .quotient(div_q)
    );

    always_comb begin
        key_we   = (state_reg == ALLOC);
        data_we  = 1'b0;
        wr_meter = '0;
        if (state_reg == UPD) begin
            data_we  = 1'b1;
            wr_meter = cur_reg;
            if (!qty_reg[63]) begin
                wr_meter.out_qty_sum   = cur_reg.out_qty_sum + {qty_reg[63:32], 32'd0};
                wr_meter.out_value_sum = cur_reg.out_value_sum + add_val;
            end else begin
                wr_meter.in_value_sum = cur_reg.in_value_sum + add_val;
            end
        end else if (state_reg == TWR) begin
            data_we  = 1'b1;
            wr_meter = cur_reg;
            wr_meter.out_value_sum = '0;
            wr_meter.out_qty_sum   = '0;
            wr_meter.in_value_sum  = '0;
        end else if (state_reg == ALLOC) begin
            data_we = 1'b1;
        end
    end

    always_comb begin
        div_start = (state_reg == DGO) && !(step_reg == pkefm_pkg::STEP_PRICE && !price_ok);
        div_a = cur_reg.out_value_sum;
        div_b = {1'b0, ticks_reg};
        case (step_reg)
            pkefm_pkg::STEP_EMA_OUT: begin
                div_a = sout_reg - cur_reg.ema_output;
                div_b = win_eff;
            end
            pkefm_pkg::STEP_IN: begin
                div_a = cur_reg.in_value_sum;
            end
            pkefm_pkg::STEP_EMA_IN: begin
                div_a = sin_reg - cur_reg.ema_input;
                div_b = win_eff;
            end
            pkefm_pkg::STEP_PRICE: begin
                div_a = 64'($signed(cur_reg.out_value_sum) >>> 16);
                div_b = cur_reg.out_qty_sum[63:32];
            end
            pkefm_pkg::STEP_EMA_PR: begin
                div_a = sp_reg - cur_reg.ema_unit_price;
                div_b = win_eff;
            end
            default: begin
                div_a = cur_reg.out_value_sum;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= IDLE;
            window_reg <= pkefm_pkg::WINDOW_RESET;
            cnt_reg    <= '0;
            m_valid    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                window_reg <= cfg_wr_data;
            end
            if (m_valid && m_ready && state_reg != FIN) begin
                m_valid <= 1'b0;
            end
            unique case (state_reg)
                IDLE: begin
                    if (s_valid) begin
                        mode_reg   <= s_mode;
                        key_reg    <= s_org_key;
                        uv_reg     <= s_unit_value;
                        qty_reg    <= s_quantity;
                        ticks_reg  <= s_tick_count;
                        idx_reg    <= '0;
                        hit_reg    <= 1'b0;
                        status_reg <= pkefm_pkg::ST_IGNORED;
                        state_reg  <= FIN;
                        if (s_mode == pkefm_pkg::MODE_RECORD) begin
                            if (s_org_key != 32'd0 && s_quantity != 64'd0) begin
                                state_reg <= SRD;
                            end
                        end else if (s_mode == pkefm_pkg::MODE_TICK) begin
                            if (s_tick_count != 31'd0) begin
                                state_reg <= TRD;
                            end
                        end else if (s_mode == pkefm_pkg::MODE_QUERY) begin
                            state_reg <= SRD;
                        end
                    end
                end
                SRD: begin
                    if (idx_reg == cnt_reg || key_reg == 32'd0) begin
                        state_reg <= FIN;
                        if (mode_reg == pkefm_pkg::MODE_QUERY) begin
                            status_reg <= pkefm_pkg::ST_NOT_FOUND;
                        end else if (cnt_reg == FULL) begin
                            status_reg <= pkefm_pkg::ST_FULL;
                        end else begin
                            state_reg <= ALLOC;
                        end
                    end else begin
                        state_reg <= SCMP;
                    end
                end
                SCMP: begin
                    if (key_rdata == key_reg) begin
                        state_reg <= DRD;
                    end else begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= SRD;
                    end
                end
                ALLOC: begin
                    cnt_reg   <= cnt_reg + CW'(1);
                    state_reg <= DRD;
                end
                DRD: begin
                    state_reg <= DWAIT;
                end
                DWAIT: begin
                    cur_reg <= rd_meter;
                    if (mode_reg == pkefm_pkg::MODE_QUERY) begin
                        hit_reg    <= 1'b1;
                        status_reg <= pkefm_pkg::ST_DONE;
                        state_reg  <= FIN;
                    end else if (qty_reg[63:32] == 32'd0) begin
                        state_reg <= FIN;
                    end else begin
                        state_reg <= MUL;
                    end
                end
                MUL: begin
                    prod_reg  <= $signed(uv_reg) * $signed(qty_reg[63:32]);
                    state_reg <= UPD;
                end
                UPD: begin
                    status_reg <= pkefm_pkg::ST_DONE;
                    state_reg  <= FIN;
                end
                TRD: begin
                    if (idx_reg == cnt_reg) begin
                        status_reg <= pkefm_pkg::ST_DONE;
                        state_reg  <= FIN;
                    end else begin
                        state_reg <= TWAIT;
                    end
                end
                TWAIT: begin
                    state_reg <= DGO;
                    step_reg  <= pkefm_pkg::STEP_OUT;
                    cur_reg   <= rd_meter;
                end
                DGO: begin
                    if (step_reg == pkefm_pkg::STEP_PRICE && !price_ok) begin
                        sp_reg   <= cur_reg.ema_unit_price;
                        step_reg <= pkefm_pkg::STEP_EMA_PR;
                    end else begin
                        state_reg <= DWT;
                    end
                end
                DWT: begin
                    if (div_done) begin
                        state_reg <= DGO;
                        step_reg  <= step_reg + 3'd1;
                        case (step_reg)
                            pkefm_pkg::STEP_OUT:     sout_reg <= div_q;
                            pkefm_pkg::STEP_EMA_OUT: cur_reg.ema_output <= cur_reg.ema_output + div_q;
                            pkefm_pkg::STEP_IN:      sin_reg <= div_q;
                            pkefm_pkg::STEP_EMA_IN:  cur_reg.ema_input <= cur_reg.ema_input + div_q;
                            pkefm_pkg::STEP_PRICE:   sp_reg <= {div_q[47:0], 16'd0};
                            default: begin
                                cur_reg.ema_unit_price <= cur_reg.ema_unit_price + div_q;
                                state_reg <= TWR;
                            end
                        endcase
                    end
                end
                TWR: begin
                    idx_reg   <= idx_reg + CW'(1);
                    state_reg <= TRD;
                end
                FIN: begin
                    if (!m_valid || m_ready) begin
                        m_valid       <= 1'b1;
                        m_status      <= status_reg;
                        m_output_rate <= hit_reg ? cur_reg.ema_output : 64'd0;
                        m_input_rate  <= hit_reg ? cur_reg.ema_input : 64'd0;
                        m_net_rate    <= hit_reg ? (cur_reg.ema_output - cur_reg.ema_input)
                                                 : 64'd0;
                        m_price_level <= hit_reg ? cur_reg.ema_unit_price : 64'd0;
                        state_reg     <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

>>> src/pkefm_checker.sv
// Port-level checker for the flow meter block, bound to the top level.
// Depends on per_key_ema_flow_meter_unit_macros.svh and pkefm_pkg.
`default_nettype none
`include "per_key_ema_flow_meter_unit_macros.svh"
module pkefm_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_valid,
    input wire        s_ready,
    input wire        m_valid,
    input wire        m_ready,
    input wire [1:0]  m_status,
    input wire [63:0] m_output_rate,
    input wire [63:0] m_input_rate,
    input wire [63:0] m_net_rate,
    input wire [63:0] m_price_level
);
    `PKEFM_ASSERT_RST(a_reset_clears_out, aclk, !aresetn, !m_valid)
    `PKEFM_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready)
    `PKEFM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
                       m_valid && $stable(m_status) && $stable(m_price_level))
    `PKEFM_ASSERT_NOW(a_zero_unless_done, aclk, aresetn,
                      m_valid && m_status != pkefm_pkg::ST_DONE,
                      m_output_rate == 64'd0 && m_input_rate == 64'd0 &&
                      m_net_rate == 64'd0 && m_price_level == 64'd0)
endmodule

bind per_key_ema_flow_meter_unit pkefm_checker u_pkefm_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_output_rate(m_output_rate), .m_input_rate(m_input_rate),
    .m_net_rate(m_net_rate), .m_price_level(m_price_level)
);
`default_nettype wire
